### hdl/similarity_mask_overlap_score_macros.svh
// Assertion helpers used by the block's top-level RTL file.
// Both expect signals named clk and arst_n in the scope where they are used.
`ifndef SIMILARITY_MASK_OVERLAP_SCORE_MACROS_SVH
`define SIMILARITY_MASK_OVERLAP_SCORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SMOS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SMOS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/smos_pkg.sv
`default_nettype none
package smos_pkg;

	localparam int CTRL_DEPTH    = 256;
	localparam int MASK_COLS     = 256;
	localparam int MASK_ROWS     = 256;
	localparam int WORDS_PER_ROW = (MASK_COLS + 31) / 32;
	localparam int MASK_DEPTH    = MASK_ROWS * WORDS_PER_ROW;
	localparam int CP_AW         = $clog2(CTRL_DEPTH);
	localparam int MASK_AW       = $clog2(MASK_DEPTH);

	localparam int SLOT_W   = 11;
	localparam int COORD_W  = 16;
	localparam int DIFF_W   = 17;
	localparam int DW       = 34;  // squared source distance, unsigned
	localparam int SW       = 35;  // setup products, signed
	localparam int PW       = 52;  // per-point products, signed
	localparam int DAW      = 50;  // destination offset times distance, signed
	localparam int XW       = 53;  // mapped coordinate times distance, signed
	localparam int CELL_W   = 8;   // mask row or column index
	localparam int DIV_STEPS = CELL_W;
	localparam int FRAC_SH  = 4;   // Q12.4 to whole cells
	localparam int LIM_SH   = FRAC_SH + CELL_W;
	localparam int HIT_W    = 9;
	localparam int CFG_W    = 17;
	localparam int TCW      = 26;  // threshold times count

	localparam int IN_TDATA_W  = 176;
	localparam int OUT_TDATA_W = 16;

	localparam logic [1:0] CMD_LOAD_POINT = 2'd0;
	localparam logic [1:0] CMD_LOAD_MASK  = 2'd1;
	localparam logic [1:0] CMD_SCORE      = 2'd2;

	localparam logic [1:0] REG_COUNT     = 2'd0;
	localparam logic [1:0] REG_WIDTH     = 2'd1;
	localparam logic [1:0] REG_HEIGHT    = 2'd2;
	localparam logic [1:0] REG_THRESHOLD = 2'd3;

	typedef struct packed {
		logic wr_point;
		logic wr_mask;
		logic capture;
		logic setup_a;
		logic setup_b;
		logic issue;
		logic publish;
	} smos_ctl_t;

	typedef struct packed {
		logic degen;
		logic count_zero;
		logic issue_last;
		logic pipe_empty;
		logic out_free;
	} smos_sts_t;

endpackage
`default_nettype wire

### hdl/smos_ctrl.sv
`default_nettype none
module smos_ctrl import smos_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	input  wire logic [1:0] command,
	output logic            s_tready,
	output smos_ctl_t       ctl,
	input  wire smos_sts_t  sts
);

	typedef enum logic [5:0] {
		ST_IDLE    = 6'b000001,
		ST_SETUP_A = 6'b000010,
		ST_SETUP_B = 6'b000100,
		ST_RUN     = 6'b001000,
		ST_DRAIN   = 6'b010000,
		ST_DONE    = 6'b100000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		ctl      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					unique case (command)
						CMD_LOAD_POINT: ctl.wr_point = 1'b1;
						CMD_LOAD_MASK:  ctl.wr_mask = 1'b1;
						CMD_SCORE: begin
							ctl.capture = 1'b1;
							state_d     = ST_SETUP_A;
						end
						default: ;
					endcase
				end
			end
			ST_SETUP_A: begin
				ctl.setup_a = 1'b1;
				state_d     = ST_SETUP_B;
			end
			ST_SETUP_B: begin
				ctl.setup_b = 1'b1;
				state_d     = (sts.degen || sts.count_zero) ? ST_DONE : ST_RUN;
			end
			ST_RUN: begin
				ctl.issue = 1'b1;
				if (sts.issue_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (sts.pipe_empty) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (sts.out_free) begin
					ctl.publish = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule
`default_nettype wire

### hdl/smos_datapath.sv
`default_nettype none
module smos_datapath import smos_pkg::*; (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire smos_ctl_t                 ctl,
	output smos_sts_t                      sts,
	input  wire logic [SLOT_W-1:0]         slot,
	input  wire logic [31:0]               mask_bits,
	input  wire logic signed [COORD_W-1:0] src_ax,
	input  wire logic signed [COORD_W-1:0] src_ay,
	input  wire logic signed [COORD_W-1:0] src_bx,
	input  wire logic signed [COORD_W-1:0] src_by,
	input  wire logic signed [COORD_W-1:0] dst_ax,
	input  wire logic signed [COORD_W-1:0] dst_ay,
	input  wire logic signed [COORD_W-1:0] dst_bx,
	input  wire logic signed [COORD_W-1:0] dst_by,
	input  wire logic                      cfg_valid,
	input  wire logic [1:0]                cfg_index,
	input  wire logic [CFG_W-1:0]          cfg_data,
	output logic                           m_tvalid,
	input  wire logic                      m_tready,
	output logic [HIT_W-1:0]               hit_count,
	output logic                           passed,
	output logic                           degenerate
);

	// Configuration registers and their clamped views.
	logic [8:0]       count_q, width_q, height_q;
	logic [CFG_W-1:0] thresh_q;
	logic [8:0]       count_eff, w_eff, h_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			width_q  <= 9'(MASK_COLS);
			height_q <= 9'(MASK_ROWS);
			thresh_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_COUNT:     count_q <= cfg_data[8:0];
				REG_WIDTH:     width_q <= cfg_data[8:0];
				REG_HEIGHT:    height_q <= cfg_data[8:0];
				REG_THRESHOLD: thresh_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign count_eff = (count_q > 9'(CTRL_DEPTH)) ? 9'(CTRL_DEPTH) : count_q;
	assign w_eff     = (width_q > 9'(MASK_COLS)) ? 9'(MASK_COLS) : width_q;
	assign h_eff     = (height_q > 9'(MASK_ROWS)) ? 9'(MASK_ROWS) : height_q;

	// Score item capture.
	logic signed [COORD_W-1:0] sax_q, say_q, dax_q, day_q;
	logic signed [DIFF_W-1:0]  dxs_q, dys_q, dxd_q, dyd_q;
	logic signed [DIFF_W-1:0]  dxs_w, dys_w;
	logic                      degen_q;

	assign dxs_w = DIFF_W'(src_bx) - DIFF_W'(src_ax);
	assign dys_w = DIFF_W'(src_by) - DIFF_W'(src_ay);

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			sax_q   <= src_ax;
			say_q   <= src_ay;
			dax_q   <= dst_ax;
			day_q   <= dst_ay;
			dxs_q   <= dxs_w;
			dys_q   <= dys_w;
			dxd_q   <= DIFF_W'(dst_bx) - DIFF_W'(dst_ax);
			dyd_q   <= DIFF_W'(dst_by) - DIFF_W'(dst_ay);
			degen_q <= (dxs_w == '0) && (dys_w == '0);
		end
	end

	// Transform setup: distance and rotation terms, then the offsets.
	logic signed [SW-1:0]  ex, ey, edx, edy, d_w;
	logic [DW-1:0]         d_q;
	logic signed [SW-1:0]  a_q, b_q;
	logic signed [DAW-1:0] dd_w, daxd_q, dayd_q;
	logic [TCW-1:0]        thrcnt_q;

	assign ex  = SW'(dxs_q);
	assign ey  = SW'(dys_q);
	assign edx = SW'(dxd_q);
	assign edy = SW'(dyd_q);
	assign d_w = ex * ex + ey * ey;
	assign dd_w = DAW'($signed({1'b0, d_q}));

	always_ff @(posedge clk) begin
		if (ctl.setup_a) begin
			d_q <= d_w[DW-1:0];
			a_q <= edx * ex + edy * ey;
			b_q <= edy * ex - edx * ey;
		end
		if (ctl.setup_b) begin
			daxd_q   <= DAW'(dax_q) * dd_w;
			dayd_q   <= DAW'(day_q) * dd_w;
			thrcnt_q <= TCW'(thresh_q) * TCW'(count_eff);
		end
	end

	// Point issue counter and hit accumulator.
	logic [8:0]       k_q;
	logic [HIT_W-1:0] hits_q;
	logic             hit_bit;

	assign sts.issue_last = (9'(k_q + 9'd1) == count_eff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q    <= '0;
			hits_q <= '0;
		end else if (ctl.capture) begin
			k_q    <= '0;
			hits_q <= '0;
		end else begin
			if (ctl.issue) begin
				k_q <= 9'(k_q + 9'd1);
			end
			if (hit_bit) begin
				hits_q <= HIT_W'(hits_q + 1'b1);
			end
		end
	end

	// Stores.
	logic [31:0] cp_mem [CTRL_DEPTH];
	logic [31:0] mask_mem [MASK_DEPTH];
	logic [31:0] cp_rd_s1;
	logic [31:0] mask_rd_s14;
	logic [MASK_AW-1:0] maddr;

	always_ff @(posedge clk) begin
		if (ctl.wr_point && (slot < SLOT_W'(CTRL_DEPTH))) begin
			cp_mem[slot[CP_AW-1:0]] <= {src_ay, src_ax};
		end
		cp_rd_s1 <= cp_mem[k_q[CP_AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (ctl.wr_mask && ({1'b0, slot} < (SLOT_W + 1)'(MASK_DEPTH))) begin
			mask_mem[slot[MASK_AW-1:0]] <= mask_bits;
		end
		mask_rd_s14 <= mask_mem[maddr];
	end

	// Point pipeline payload.
	logic signed [DIFF_W-1:0] ux_s2, uy_s2;
	logic signed [PW-1:0]     pax_s3, pby_s3, pbx_s3, pay_s3;
	logic signed [PW-1:0]     a_e, b_e, ux_e, uy_e;
	logic signed [XW-1:0]     x_s4, y_s4;
	logic [XW-1:0]            rem_x_s5, rem_y_s5, lim;
	logic                     ok_s5;

	assign a_e  = PW'(a_q);
	assign b_e  = PW'(b_q);
	assign ux_e = PW'(ux_s2);
	assign uy_e = PW'(uy_s2);
	assign lim  = XW'(d_q) << LIM_SH;

	always_ff @(posedge clk) begin
		ux_s2    <= DIFF_W'($signed(cp_rd_s1[15:0])) - DIFF_W'(sax_q);
		uy_s2    <= DIFF_W'($signed(cp_rd_s1[31:16])) - DIFF_W'(say_q);
		pax_s3   <= a_e * ux_e;
		pby_s3   <= b_e * uy_e;
		pbx_s3   <= b_e * ux_e;
		pay_s3   <= a_e * uy_e;
		x_s4     <= XW'(pax_s3) - XW'(pby_s3) + XW'(daxd_q);
		y_s4     <= XW'(pbx_s3) + XW'(pay_s3) + XW'(dayd_q);
		// A negative value is a miss even when it would truncate to zero.
		ok_s5    <= !x_s4[XW-1] && ($unsigned(x_s4) < lim)
			&& !y_s4[XW-1] && ($unsigned(y_s4) < lim);
		rem_x_s5 <= $unsigned(x_s4);
		rem_y_s5 <= $unsigned(y_s4);
	end

	// Restoring division by 16*D, one quotient bit per stage, both axes.
	logic [XW-1:0]     rx_sd [DIV_STEPS];
	logic [XW-1:0]     ry_sd [DIV_STEPS];
	logic [CELL_W-1:0] qx_sd [DIV_STEPS];
	logic [CELL_W-1:0] qy_sd [DIV_STEPS];
	logic              okd_sd [DIV_STEPS];
	logic [DIV_STEPS-1:0] vd_sd;

	for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
		logic [XW-1:0]     rxi, ryi, dsh;
		logic [CELL_W-1:0] qxi, qyi;
		logic              oki, gex, gey;
		if (j == 0) begin : g_first
			assign rxi = rem_x_s5;
			assign ryi = rem_y_s5;
			assign qxi = '0;
			assign qyi = '0;
			assign oki = ok_s5;
		end else begin : g_rest
			assign rxi = rx_sd[j-1];
			assign ryi = ry_sd[j-1];
			assign qxi = qx_sd[j-1];
			assign qyi = qy_sd[j-1];
			assign oki = okd_sd[j-1];
		end
		assign dsh = XW'(d_q) << (FRAC_SH + DIV_STEPS - 1 - j);
		assign gex = (rxi >= dsh);
		assign gey = (ryi >= dsh);
		always_ff @(posedge clk) begin
			rx_sd[j]  <= gex ? rxi - dsh : rxi;
			ry_sd[j]  <= gey ? ryi - dsh : ryi;
			qx_sd[j]  <= {qxi[CELL_W-2:0], gex};
			qy_sd[j]  <= {qyi[CELL_W-2:0], gey};
			okd_sd[j] <= oki;
		end
	end

	// Mask lookup.
	logic [CELL_W-1:0] col, row;
	logic [4:0]        bit_s14;
	logic              hitok_s14;

	assign col   = qx_sd[DIV_STEPS-1];
	assign row   = qy_sd[DIV_STEPS-1];
	assign maddr = MASK_AW'({row, col[CELL_W-1:5]});

	always_ff @(posedge clk) begin
		bit_s14   <= col[4:0];
		hitok_s14 <= okd_sd[DIV_STEPS-1] && ({1'b0, col} < w_eff) && ({1'b0, row} < h_eff);
	end

	// Valid bits of the point pipeline.
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s14;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			vd_sd <= '0;
			v_s14 <= 1'b0;
		end else begin
			v_s1  <= ctl.issue;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			v_s5  <= v_s4;
			vd_sd <= {vd_sd[DIV_STEPS-2:0], v_s5};
			v_s14 <= vd_sd[DIV_STEPS-1];
		end
	end

	assign hit_bit = v_s14 && hitok_s14 && mask_rd_s14[bit_s14];

	assign sts.pipe_empty = !(v_s1 || v_s2 || v_s3 || v_s4 || v_s5 || (|vd_sd) || v_s14);
	assign sts.degen      = degen_q;
	assign sts.count_zero = (count_eff == '0);

	// Output register.
	logic m_tvalid_q, passed_q, degen_out_q;
	logic [HIT_W-1:0] hit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (ctl.publish) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.publish) begin
			hit_q       <= hits_q;
			passed_q    <= (count_eff != '0) && (TCW'({hits_q, 16'b0}) >= thrcnt_q);
			degen_out_q <= degen_q;
		end
	end

	assign sts.out_free = !m_tvalid_q || m_tready;
	assign m_tvalid     = m_tvalid_q;
	assign hit_count    = hit_q;
	assign passed       = passed_q;
	assign degenerate   = degen_out_q;

endmodule
`default_nettype wire

### hdl/similarity_mask_overlap_score.sv
// Similarity-transform mask overlap scorer.
// Input stream: s_tuser carries the command (load control point, load mask
// word, score). Loads give no result. A score word maps
// the first control_count stored points through the transform fixed by its
// two source and two destination points and counts those landing on set
// mask bits.
// A score runs from acceptance to the result through the setup states
// SETUP_A and SETUP_B, a pass issuing one point per cycle through the control
// store read port, and a 14-stage drain of the map, divide and mask read pipeline.
// Only one word is in work at a time; s_tready is low while a score runs.
// Degenerate source pairs or a zero count skip the point pass.
// The result sits in an output register, so loads are still taken while the
// receiver stalls; a following score finishes and then waits for it to drain.
// Reset empties the pipeline and output and restores the register defaults;
// the stores hold garbage until loaded. The configuration channel is always
// ready and must only be written while the block is idle.
`default_nettype none
`include "similarity_mask_overlap_score_macros.svh"
module similarity_mask_overlap_score import smos_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	// slot, mask_bits, src_ax, src_ay, src_bx, src_by, dst_ax, dst_ay, dst_bx, dst_by
	input  wire logic [IN_TDATA_W-1:0]  s_tdata,
	// command
	input  wire logic [1:0]             s_tuser,
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	// hit_count, passed, degenerate
	output logic [OUT_TDATA_W-1:0]      m_tdata,
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [1:0]             cfg_index,
	input  wire logic [CFG_W-1:0]       cfg_data
);

	smos_ctl_t        ctl;
	smos_sts_t        sts;
	logic [HIT_W-1:0] hit_count;
	logic             passed, degenerate;

	smos_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.command  (s_tuser),
		.s_tready (s_tready),
		.ctl      (ctl),
		.sts      (sts)
	);

	smos_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.sts        (sts),
		.slot       (s_tdata[10:0]),
		.mask_bits  (s_tdata[42:11]),
		.src_ax     (s_tdata[58:43]),
		.src_ay     (s_tdata[74:59]),
		.src_bx     (s_tdata[90:75]),
		.src_by     (s_tdata[106:91]),
		.dst_ax     (s_tdata[122:107]),
		.dst_ay     (s_tdata[138:123]),
		.dst_bx     (s_tdata[154:139]),
		.dst_by     (s_tdata[170:155]),
		.cfg_valid  (cfg_valid),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.hit_count  (hit_count),
		.passed     (passed),
		.degenerate (degenerate)
	);

	assign cfg_ready = 1'b1;
	assign m_tdata   = {(OUT_TDATA_W - HIT_W - 2)'(0), degenerate, passed, hit_count};

	`SMOS_ASSERT_NEXT(a_busy_after_score, s_tvalid && s_tready && (s_tuser == CMD_SCORE), !s_tready, "score word accepted but input still ready")
	`SMOS_ASSERT_NOW(a_publish_free, ctl.publish, !m_tvalid || m_tready, "result overwrote a word not yet taken")
	`SMOS_ASSERT_NOW(a_degen_no_hits, m_tvalid && degenerate, hit_count == '0, "degenerate result with hits")
	`SMOS_ASSERT_NOW(a_issue_drained, ctl.capture, sts.pipe_empty, "score started with points in flight")

endmodule
`default_nettype wire
